@@ design/websocket_text_frame_deframer_assert.svh @@
// assertion macros shared by the deframer modules
// expects clk and arst_n in the scope of each use
`ifndef WEBSOCKET_TEXT_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_TEXT_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define WTFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define WTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/wtfd_pkg.sv @@
// shared types and constants for the websocket text frame deframer
// no dependencies
`timescale 1ns / 1ps

package wtfd_pkg;

	localparam int PHASE_W  = 3;
	localparam int STATUS_W = 3;
	localparam int LEN_W    = 16;
	localparam int KEY_W    = 32;

	// parse phases
	localparam logic [PHASE_W-1:0] PH_HDR0    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_HDR1    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LENHI   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LENLO   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_KEY     = 3'd4;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd5;
	localparam logic [PHASE_W-1:0] PH_DONE    = 3'd6;
	localparam logic [PHASE_W-1:0] PH_SKIP    = 3'd7;

	// frame status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_TEXT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LEN64     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNMASKED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd4;

	// header field constants
	localparam logic [7:0] FIN_BIT     = 8'h80;
	localparam logic [7:0] OPCODE_MASK = 8'h0f;
	localparam logic [3:0] OPCODE_TEXT = 4'h1;
	localparam logic [6:0] LEN_EXT16   = 7'd126;
	localparam logic [6:0] LEN_EXT64   = 7'd127;
	localparam logic [LEN_W-1:0] KEY_BYTES = 16'd4;

	// one result item
	typedef struct packed {
		logic [7:0]          data;
		logic                valid;
		logic                frame_end;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

@@ design/websocket_text_frame_deframer.sv @@
// A byte accepted into the input register passes through the parser logic into the
// result register and transfers out from there. Throughput: one byte per cycle
// while out_stall is low; an input register and a result register with the parser
// logic between them, state updated as each byte moves on.
// Reset: arst_n clears the parse state and both valid flags at once.
// Depends on wtfd_pkg, wtfd_parser and the deframer assertion macros.
`timescale 1ns / 1ps
`include "websocket_text_frame_deframer_assert.svh"

module websocket_text_frame_deframer import wtfd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                buffer_end,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          payload_byte,
	output logic                byte_valid,
	output logic                frame_end,
	output logic [STATUS_W-1:0] status
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       advance;
	res_t       res;
	res_t       res_q;
	logic       out_valid_q;

	// result register free or draining this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= rx_byte;
			end_s1  <= buffer_end;
		end
	end

	wtfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.rx_byte (byte_s1),
		.last    (end_s1),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = res_q.data;
	assign byte_valid   = res_q.valid;
	assign frame_end    = res_q.frame_end;
	assign status       = res_q.status;

	// stall only while a byte waits behind a held result
	`WTFD_ASSERT_NOW(a_stall_cause, in_stall, valid_s1 && out_valid_q && out_stall,
		"input stalled without a blocked transfer")
	// status is zero away from the buffer end
	`WTFD_ASSERT_NOW(a_status_quiet, out_valid_q && !res_q.frame_end, res_q.status == ST_OK,
		"status set before buffer end")
	// no data byte without byte_valid
	`WTFD_ASSERT_NOW(a_data_zero, out_valid_q && !res_q.valid, res_q.data == 8'd0,
		"data present without byte_valid")

endmodule

@@ design/wtfd_parser.sv @@
// frame header parser and payload unmasker for one byte per step
// depends on wtfd_pkg and the deframer assertion macros
`timescale 1ns / 1ps
`include "websocket_text_frame_deframer_assert.svh"

module wtfd_parser import wtfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  logic       last,
	output res_t       res
);

	logic [PHASE_W-1:0]  phase_q, phase_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [KEY_W-1:0]    key_q, key_d;
	logic [LEN_W-1:0]    idx_q, idx_d;
	logic [STATUS_W-1:0] err_q, err_d;
	logic [LEN_W-1:0]    idx_inc;
	logic [6:0]          len7;
	logic                short_buf;
	logic [7:0]          key_byte;

	assign idx_inc = idx_q + 16'd1;
	assign len7    = rx_byte[6:0];

	// key byte for the current payload position, first key byte on top
	always_comb begin
		unique case (idx_q[1:0])
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state and result for the byte in hand
	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		key_d     = key_q;
		idx_d     = idx_q;
		err_d     = err_q;
		short_buf = 1'b0;
		res       = '0;

		unique case (phase_q)
			PH_HDR0: begin
				if (last) begin
					short_buf = 1'b1;
				end else if ((rx_byte & FIN_BIT) == 8'd0 ||
						(rx_byte & OPCODE_MASK) != {4'd0, OPCODE_TEXT}) begin
					err_d   = ST_NOT_TEXT;
					phase_d = PH_SKIP;
				end else begin
					phase_d = PH_HDR1;
				end
			end
			PH_HDR1: begin
				if (len7 == LEN_EXT64) begin
					err_d   = ST_LEN64;
					phase_d = PH_SKIP;
				end else if (!rx_byte[7]) begin
					err_d   = ST_UNMASKED;
					phase_d = PH_SKIP;
				end else if (len7 == LEN_EXT16) begin
					phase_d = PH_LENHI;
				end else begin
					len_d   = {9'd0, len7};
					idx_d   = '0;
					phase_d = PH_KEY;
				end
			end
			PH_LENHI: begin
				len_d   = {rx_byte, 8'd0};
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				len_d   = {len_q[15:8], rx_byte};
				idx_d   = '0;
				phase_d = PH_KEY;
			end
			PH_KEY: begin
				key_d = {key_q[23:0], rx_byte};
				idx_d = idx_inc;
				if (idx_inc >= KEY_BYTES) begin
					idx_d   = '0;
					phase_d = (len_q == '0) ? PH_DONE : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				res.data  = rx_byte ^ key_byte;
				res.valid = 1'b1;
				idx_d     = idx_inc;
				if (idx_inc >= len_q) begin
					phase_d = PH_DONE;
				end
			end
			default: begin
			end
		endcase

		// buffer end: report status and start over
		res.frame_end = last;
		if (last) begin
			priority if (short_buf) begin
				res.status = ST_TRUNCATED;
			end else if (err_d != ST_OK) begin
				res.status = err_d;
			end else if (phase_d == PH_DONE) begin
				res.status = ST_OK;
			end else begin
				res.status = ST_TRUNCATED;
			end
			phase_d = PH_HDR0;
			len_d   = '0;
			key_d   = '0;
			idx_d   = '0;
			err_d   = ST_OK;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			len_q   <= '0;
			key_q   <= '0;
			idx_q   <= '0;
			err_q   <= ST_OK;
		end else if (step) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			key_q   <= key_d;
			idx_q   <= idx_d;
			err_q   <= err_d;
		end
	end

	// error code and skip phase go together
	`WTFD_ASSERT_NOW(a_skip_has_err, phase_q == PH_SKIP, err_q != ST_OK, "skip without error")
	`WTFD_ASSERT_NOW(a_err_in_skip, err_q != ST_OK, phase_q == PH_SKIP, "error outside skip")
	// last byte always returns parser to the first header byte
	`WTFD_ASSERT_NEXT(a_last_clears, step && last, phase_q == PH_HDR0 && err_q == ST_OK,
		"state not cleared after buffer end")

endmodule

@@ test/tb_websocket_text_frame_deframer.sv @@
// testbench for websocket_text_frame_deframer: directed table, then random buffers
// checked against an in-bench frame parser; depends on wtfd_pkg and the deframer rtl
`timescale 1ns / 1ps

module tb_websocket_text_frame_deframer;
	import wtfd_pkg::*;

	localparam int NUM_ITEMS   = 850;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_SHOWN   = 48;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [7:0]          rx_byte;
	logic                buffer_end;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [7:0]          payload_byte;
	logic                byte_valid;
	logic                frame_end;
	logic [STATUS_W-1:0] status;

	websocket_text_frame_deframer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.buffer_end   (buffer_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.byte_valid   (byte_valid),
		.frame_end    (frame_end),
		.status       (status)
	);

	always #5 clk = ~clk;

	// one row of the directed table; fixed_res is used only where has_fixed is set
	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         has_fixed;
		res_t       fixed_res;
	} stim_row_t;

	localparam res_t NO_RES = '0;

	stim_row_t dir_rows [26] = '{
		// one-byte buffer
		'{8'h81, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_TRUNCATED}},
		// fin clear with text opcode
		'{8'h01, 1'b0, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_NOT_TEXT}},
		// 64-bit length
		'{8'h81, 1'b0, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_LEN64}},
		// unmasked, length field 126
		'{8'h81, 1'b0, 1'b0, NO_RES},
		'{8'h7e, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_UNMASKED}},
		// zero payload, complete after the last key byte
		'{8'h81, 1'b0, 1'b0, NO_RES},
		'{8'h80, 1'b0, 1'b0, NO_RES},
		'{8'hff, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'ha5, 1'b0, 1'b0, NO_RES},
		'{8'h5a, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK}},
		// extended length below 126, reserved bits set, trailing byte ignored
		'{8'hf1, 1'b0, 1'b0, NO_RES},
		'{8'hfe, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h02, 1'b0, 1'b0, NO_RES},
		'{8'h12, 1'b0, 1'b0, NO_RES},
		'{8'h34, 1'b0, 1'b0, NO_RES},
		'{8'h56, 1'b0, 1'b0, NO_RES},
		'{8'h78, 1'b0, 1'b0, NO_RES},
		'{8'h12, 1'b0, 1'b0, NO_RES},
		'{8'hff, 1'b0, 1'b0, NO_RES},
		'{8'hee, 1'b1, 1'b0, NO_RES},
		// binary opcode with fin set
		'{8'h82, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_NOT_TEXT}}
	};

	res_t pending_results [$];
	int   errors = 0;
	int   sent_cnt = 0;
	int   cycles = 0;
	bit   tx_calm = 1'b0;
	bit   rx_calm = 1'b0;
	int   rx_hold = 0;

	// parser state of the frame being received
	logic [PHASE_W-1:0]  fr_phase;
	logic [LEN_W-1:0]    fr_len;
	logic [KEY_W-1:0]    fr_key;
	logic [LEN_W-1:0]    fr_idx;
	logic [STATUS_W-1:0] fr_err;

	function automatic void clear_frame();
		fr_phase = PH_HDR0;
		fr_len   = '0;
		fr_key   = '0;
		fr_idx   = '0;
		fr_err   = ST_OK;
	endfunction

	// advance the frame parser by one byte and return the result it gives
	function automatic res_t deframe_byte(input logic [7:0] b, input logic last);
		res_t r;
		logic short_buf;
		r = '0;
		short_buf = 1'b0;
		case (fr_phase)
			PH_HDR0: begin
				if (last)
					short_buf = 1'b1;
				else if ((b & FIN_BIT) == 8'h00 || (b & OPCODE_MASK) != {4'h0, OPCODE_TEXT}) begin
					fr_err   = ST_NOT_TEXT;
					fr_phase = PH_SKIP;
				end else
					fr_phase = PH_HDR1;
			end
			PH_HDR1: begin
				if (b[6:0] == LEN_EXT64) begin
					fr_err   = ST_LEN64;
					fr_phase = PH_SKIP;
				end else if (!b[7]) begin
					fr_err   = ST_UNMASKED;
					fr_phase = PH_SKIP;
				end else if (b[6:0] == LEN_EXT16)
					fr_phase = PH_LENHI;
				else begin
					fr_len   = {9'd0, b[6:0]};
					fr_idx   = '0;
					fr_phase = PH_KEY;
				end
			end
			PH_LENHI: begin
				fr_len   = {b, 8'h00};
				fr_phase = PH_LENLO;
			end
			PH_LENLO: begin
				fr_len   = {fr_len[15:8], b};
				fr_idx   = '0;
				fr_phase = PH_KEY;
			end
			PH_KEY: begin
				fr_key = {fr_key[23:0], b};
				fr_idx = fr_idx + 16'd1;
				if (fr_idx >= KEY_BYTES) begin
					fr_idx   = '0;
					fr_phase = (fr_len == '0) ? PH_DONE : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				r.data  = b ^ fr_key[8 * (3 - fr_idx[1:0]) +: 8];
				r.valid = 1'b1;
				fr_idx  = fr_idx + 16'd1;
				if (fr_idx >= fr_len)
					fr_phase = PH_DONE;
			end
			default: ;
		endcase
		// status at the buffer end, then start over
		if (last) begin
			r.frame_end = 1'b1;
			if (short_buf)
				r.status = ST_TRUNCATED;
			else if (fr_err != ST_OK)
				r.status = fr_err;
			else if (fr_phase == PH_DONE)
				r.status = ST_OK;
			else
				r.status = ST_TRUNCATED;
			clear_frame();
		end
		return r;
	endfunction

	// one byte transfer; entered and left at a rising edge
	task automatic send_byte(input logic [7:0] b, input logic last, input bit has_fixed,
			input res_t fixed_res);
		int gap;
		res_t r;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		rx_byte    <= b;
		buffer_end <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = deframe_byte(b, last);
		pending_results = {pending_results, (has_fixed ? fixed_res : r)};
		sent_cnt++;
	endtask

	// stop sending until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// build one random buffer and send it; ext_len >= 0 forces a full extended frame
	task automatic send_buffer(input int ext_len);
		logic [7:0] bq [$];
		int kind, sel, len, shown, cut;
		kind = (ext_len >= 0) ? 9 : $urandom_range(0, 9);
		if (kind == 0) begin
			// noise
			repeat ($urandom_range(1, 6)) bq = {bq, 8'($urandom)};
		end else if (kind == 1) begin
			// broken header
			sel = $urandom_range(0, 2);
			if (sel == 0) begin
				bq = {bq, 8'($urandom)};
				if (bq[0][7] && bq[0][3:0] == OPCODE_TEXT)
					bq[0][7] = 1'b0;
			end else if (sel == 1) begin
				bq = {bq, 8'h81};
				bq = {bq, {1'($urandom), LEN_EXT64}};
			end else begin
				bq = {bq, 8'h81};
				bq = {bq, {1'b0, 7'($urandom_range(0, 126))}};
			end
			repeat ($urandom_range(0, 4)) bq = {bq, 8'($urandom)};
		end else begin
			// well-formed header with random content; payloads above MAX_SHOWN are cut short
			bq = {bq, 8'h81 | 8'($urandom_range(0, 7) << 4)};
			sel = $urandom_range(0, 15);
			if (ext_len >= 0)
				len = ext_len;
			else if (sel <= 10)
				len = $urandom_range(0, 20);
			else if (sel == 11)
				len = $urandom_range(100, 125);
			else if (sel <= 14)
				len = $urandom_range(0, 40);
			else
				len = $urandom_range(0, 65535);
			if (ext_len >= 0 || sel >= 12) begin
				bq = {bq, {1'b1, LEN_EXT16}};
				bq = {bq, 8'(len >> 8)};
				bq = {bq, 8'(len)};
			end else
				bq = {bq, {1'b1, 7'(len)}};
			repeat (4) bq = {bq, 8'($urandom)};
			shown = (ext_len < 0 && len > MAX_SHOWN) ? MAX_SHOWN : len;
			repeat (shown) bq = {bq, 8'($urandom)};
			repeat ($urandom_range(0, 3)) bq = {bq, 8'($urandom)};
		end
		// sometimes end the buffer early
		if (ext_len < 0 && $urandom_range(0, 7) == 0) begin
			cut = $urandom_range(1, bq.size());
			while (bq.size() > cut) void'(bq.pop_back());
		end
		tx_calm = ($urandom_range(0, 3) == 0);
		foreach (bq[i])
			send_byte(bq[i], i == bq.size() - 1, 1'b0, NO_RES);
	endtask

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
			errors++;
		end
	endfunction

	// result side: check each transfer and draw stalls
	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %0h %0b %0b %0d",
						$time, payload_byte, byte_valid, frame_end, status);
					errors++;
				end else begin
					e = pending_results.pop_front();
					check_field("payload_byte", 32'(e.data), 32'(payload_byte));
					check_field("byte_valid", 32'(e.valid), 32'(byte_valid));
					check_field("frame_end", 32'(e.frame_end), 32'(frame_end));
					check_field("status", 32'(e.status), 32'(status));
					if (e.frame_end)
						rx_calm = ($urandom_range(0, 3) == 0);
				end
				rx_hold = rx_calm ? 0 : $urandom_range(0, 8);
			end else if (rx_hold > 0)
				rx_hold--;
			out_stall <= (rx_hold > 0);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		rx_byte    <= 8'h00;
		buffer_end <= 1'b0;
		clear_frame();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].has_fixed,
				dir_rows[i].fixed_res);
		drain();

		// long extended frame, index past one byte
		send_buffer(260);

		// random buffers, with an occasional full drain
		while (sent_cnt < NUM_ITEMS) begin
			send_buffer(-1);
			if ($urandom_range(0, 29) == 0)
				drain();
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
